// File: rtl/ltf_pkg.sv
// ltf_pkg: shared constants, payload structs and helper functions
// for the linearized track fit block
// depends on: nothing
`default_nettype none

package ltf_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_LAYERS_DEF  = 6;
    localparam int NUM_PARAMS_DEF  = 4;
    localparam int NUM_COORDS_DEF  = 12;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths and arithmetic constants
    localparam int FIELD_W      = 32;
    localparam int OP_W         = 2;
    localparam int ROW_W        = 2;
    localparam int COL_W        = 4;
    localparam int COL_SPAN     = 16;
    localparam int DOF_W        = 3;
    localparam int Z_COL_OFFSET = 6;
    localparam int FRAC_BITS    = 16;
    localparam int ACC_W        = 64;
    localparam int MAX_OUT      = 4;

    // request opcodes
    localparam logic [OP_W-1:0] OP_HIT      = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_COEF  = 2'd1;
    localparam logic [OP_W-1:0] OP_WR_COORD = 2'd2;
    localparam logic [OP_W-1:0] OP_WR_PARAM = 2'd3;

    // input request payload
    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic [ROW_W-1:0]          row_select;
        logic [COL_W-1:0]          column_select;
        logic signed [FIELD_W-1:0] write_value;
        logic signed [FIELD_W-1:0] hit_phi;
        logic signed [FIELD_W-1:0] hit_z;
        logic                      final_hit;
    } ltf_in_t;

    // result payload
    typedef struct packed {
        logic [ROW_W-1:0]          param_number;
        logic signed [FIELD_W-1:0] param_value;
        logic [DOF_W-1:0]          degrees_freedom;
        logic                      too_many_hits;
        logic                      end_of_run;
    } ltf_out_t;

    // sequencer to datapath control
    typedef struct packed {
        logic             capture;
        logic             load_dphi;
        logic             load_dz;
        logic             coord_zero;
        logic             mac_issue;
        logic             mac_z;
        logic             mac_zero;
        logic [ROW_W-1:0] mac_param;
        logic             acc_clear;
        logic [ROW_W-1:0] sel_param;
    } ltf_mac_ctl_t;

    // address bits for a memory of the given depth
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // parameter rows that are stored and emitted
    function automatic int num_rows(input int num_params);
        return (num_params < MAX_OUT) ? num_params : MAX_OUT;
    endfunction

endpackage

`default_nettype wire

// File: rtl/ltf_ram.sv
// ltf_ram: generic single write port, single read port ram with registered read
// depends on: ltf_pkg (address width helper)
`default_nettype none

module ltf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   we,
    input  wire logic [ltf_pkg::addr_bits(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [ltf_pkg::addr_bits(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/ltf_mac.sv
// ltf_mac: hit differences, coefficient multiply pipeline, accumulator bank
// and final parameter sum with saturation
// depends on: ltf_pkg
`default_nettype none

module ltf_mac #(
    parameter int VALUE_WIDTH = ltf_pkg::VALUE_WIDTH_DEF,
    parameter int NUM_PARAMS  = ltf_pkg::NUM_PARAMS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ltf_pkg::ltf_mac_ctl_t             ctl,
    input  wire logic [ltf_pkg::FIELD_W-1:0]       hit_phi,
    input  wire logic [ltf_pkg::FIELD_W-1:0]       hit_z,
    input  wire logic [VALUE_WIDTH-1:0]            coord_rdata,
    input  wire logic [VALUE_WIDTH-1:0]            coef_rdata,
    input  wire logic [VALUE_WIDTH-1:0]            param_rdata,
    output logic signed [ltf_pkg::FIELD_W-1:0]     fit_value
);

    localparam int VW       = VALUE_WIDTH;
    localparam int DW       = VW + 1;
    localparam int PW       = 2 * VW;
    localparam int ACC_W    = ltf_pkg::ACC_W;
    localparam int FRAC     = ltf_pkg::FRAC_BITS;
    localparam int SHW      = ACC_W - FRAC;
    localparam int SUM_W    = SHW + 1;
    localparam int NUM_ROWS = ltf_pkg::num_rows(NUM_PARAMS);
    localparam int PA_W     = ltf_pkg::addr_bits(NUM_ROWS);

    logic signed [VW-1:0]    phi_reg;
    logic signed [VW-1:0]    z_reg;
    logic signed [VW-1:0]    dphi_reg;
    logic signed [VW-1:0]    dz_reg;
    logic                    v1_reg;
    logic                    z1_reg;
    logic                    zero1_reg;
    logic [ltf_pkg::ROW_W-1:0] p1_reg;
    logic                    v2_reg;
    logic [ltf_pkg::ROW_W-1:0] p2_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] prod_next;
    logic signed [ACC_W-1:0] acc_reg [NUM_ROWS];

    logic signed [VW-1:0]    coord_val;
    logic signed [VW-1:0]    diff_src;
    logic signed [DW-1:0]    diff;
    logic [VW-1:0]           diff_sat;
    logic signed [VW-1:0]    operand;
    logic signed [VW-1:0]    coef_s;
    logic signed [PW-1:0]    mult;
    logic [PA_W-1:0]         acc_idx;
    logic signed [ACC_W-1:0] acc_rd;
    logic signed [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0]        acc_sat;
    logic signed [SHW-1:0]   acc_sh;
    logic signed [VW-1:0]    param_s;
    logic signed [SUM_W-1:0] fit_sum;
    logic [SUM_W-VW:0]       fit_hi;
    logic                    fit_in_range;
    logic signed [VW-1:0]    fit_sat;

    // hit capture, low value bits only
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            phi_reg <= hit_phi[VW-1:0];
            z_reg   <= hit_z[VW-1:0];
        end
    end

    // coordinate difference, saturated to the value width
    assign coord_val = ctl.coord_zero ? '0 : $signed(coord_rdata);
    assign diff_src  = ctl.load_dz ? z_reg : phi_reg;
    assign diff      = DW'(diff_src) - DW'(coord_val);
    assign diff_sat  = (diff[DW-1] != diff[DW-2]) ?
                       {diff[DW-1], {(VW-1){~diff[DW-1]}}} : diff[VW-1:0];

    always_ff @(posedge aclk) begin
        if (ctl.load_dphi) begin
            dphi_reg <= diff_sat;
        end
        if (ctl.load_dz) begin
            dz_reg <= diff_sat;
        end
    end

    // multiply stage, the coefficient read arrives in the cycle after issue
    assign operand   = z1_reg ? dz_reg : dphi_reg;
    assign coef_s    = $signed(coef_rdata);
    assign mult      = PW'(coef_s) * PW'(operand);
    assign prod_next = zero1_reg ? '0 : ACC_W'(mult);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= ctl.mac_issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        z1_reg    <= ctl.mac_z;
        zero1_reg <= ctl.mac_zero;
        p1_reg    <= ctl.mac_param;
        p2_reg    <= p1_reg;
        prod_reg  <= prod_next;
    end

    // single read point into the accumulator bank
    assign acc_idx = v2_reg ? p2_reg[PA_W-1:0] : ctl.sel_param[PA_W-1:0];
    assign acc_rd  = acc_reg[acc_idx];

    // saturating accumulate at the 64-bit limits
    assign acc_sum = (ACC_W+1)'(acc_rd) + (ACC_W+1)'(prod_reg);
    assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
                     {acc_sum[ACC_W], {(ACC_W-1){~acc_sum[ACC_W]}}} :
                     acc_sum[ACC_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.acc_clear) begin
            for (int i = 0; i < NUM_ROWS; i++) begin
                acc_reg[i] <= '0;
            end
        end else if (v2_reg) begin
            acc_reg[acc_idx] <= acc_sat;
        end
    end

    // central parameter plus floored accumulator, saturated
    assign acc_sh       = acc_rd[ACC_W-1:FRAC];
    assign param_s      = $signed(param_rdata);
    assign fit_sum      = SUM_W'(param_s) + SUM_W'(acc_sh);
    assign fit_hi       = fit_sum[SUM_W-1:VW-1];
    assign fit_in_range = (&fit_hi) || !(|fit_hi);
    assign fit_sat      = fit_in_range ? fit_sum[VW-1:0] :
                          {fit_sum[SUM_W-1], {(VW-1){~fit_sum[SUM_W-1]}}};
    assign fit_value    = ltf_pkg::FIELD_W'(fit_sat);

    // pipeline and accumulator checks
    a_issue_reaches_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.mac_issue |-> ##2 v2_reg)
        else $error("issued product did not reach the accumulate stage");

    a_acc_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.acc_clear |=> (acc_reg[0] == '0))
        else $error("accumulator not cleared at end of track");

    a_no_issue_while_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.acc_clear |-> !v1_reg && !v2_reg)
        else $error("accumulate in flight while closing a track");

endmodule

`default_nettype wire

// File: rtl/ltf_seq.sv
// ltf_seq: request sequencer, memory addressing, hit counter and
// result output register
// depends on: ltf_pkg
`default_nettype none

module ltf_seq #(
    parameter int MAX_LAYERS = ltf_pkg::MAX_LAYERS_DEF,
    parameter int NUM_PARAMS = ltf_pkg::NUM_PARAMS_DEF,
    parameter int NUM_COORDS = ltf_pkg::NUM_COORDS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire ltf_pkg::ltf_in_t         s_data,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output ltf_pkg::ltf_out_t             m_data,
    input  wire logic [ltf_pkg::FIELD_W-1:0] fit_value,
    output ltf_pkg::ltf_mac_ctl_t         ctl,
    output logic                          coef_we,
    output logic [ltf_pkg::addr_bits(ltf_pkg::num_rows(NUM_PARAMS) * ltf_pkg::COL_SPAN)-1:0]
                                          coef_waddr,
    output logic [ltf_pkg::addr_bits(ltf_pkg::num_rows(NUM_PARAMS) * ltf_pkg::COL_SPAN)-1:0]
                                          coef_raddr,
    output logic                          coord_we,
    output logic [ltf_pkg::addr_bits(NUM_COORDS)-1:0] coord_waddr,
    output logic [ltf_pkg::addr_bits(NUM_COORDS)-1:0] coord_raddr,
    output logic                          param_we,
    output logic [ltf_pkg::addr_bits(ltf_pkg::num_rows(NUM_PARAMS))-1:0] param_waddr,
    output logic [ltf_pkg::addr_bits(ltf_pkg::num_rows(NUM_PARAMS))-1:0] param_raddr
);

    localparam int NUM_ROWS = ltf_pkg::num_rows(NUM_PARAMS);
    localparam int CNT_W    = $clog2(MAX_LAYERS + 1);
    localparam int STEP_W   = $clog2(2 * NUM_ROWS);
    localparam int KA_W     = ltf_pkg::addr_bits(NUM_ROWS * ltf_pkg::COL_SPAN);
    localparam int CA_W     = ltf_pkg::addr_bits(NUM_COORDS);
    localparam int PA_W     = ltf_pkg::addr_bits(NUM_ROWS);
    localparam int ROW_W    = ltf_pkg::ROW_W;
    localparam int COL_W    = ltf_pkg::COL_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CPHI   = 3'd1;
    localparam logic [2:0] S_CZ     = 3'd2;
    localparam logic [2:0] S_MAC    = 3'd3;
    localparam logic [2:0] S_DRAIN1 = 3'd4;
    localparam logic [2:0] S_DRAIN2 = 3'd5;
    localparam logic [2:0] S_ORD    = 3'd6;
    localparam logic [2:0] S_OCALC  = 3'd7;

    logic [2:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              ovf_reg,    ovf_next;
    logic              final_reg,  final_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [ROW_W-1:0]  p_reg,      p_next;
    logic              out_valid_reg, out_valid_next;
    ltf_pkg::ltf_out_t out_data_reg,  out_data_next;

    logic              accept;
    logic              is_hit;
    logic              room;
    logic [COL_W-1:0]  col_phi;
    logic [COL_W-1:0]  col_z;
    logic [ROW_W-1:0]  step_p;
    logic              step_z;
    logic [COL_W-1:0]  step_col;
    logic              out_free;
    logic              out_load;
    logic              last_p;

    // request handshake and decode
    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign is_hit  = (s_data.opcode == ltf_pkg::OP_HIT);
    assign room    = (cnt_reg < CNT_W'(MAX_LAYERS));

    // coordinate columns of the current hit
    assign col_phi  = COL_W'(cnt_reg);
    assign col_z    = col_phi + COL_W'(ltf_pkg::Z_COL_OFFSET);
    assign step_p   = ROW_W'(step_reg >> 1);
    assign step_z   = step_reg[0];
    assign step_col = step_z ? col_z : col_phi;

    // memory writes straight from accepted load requests
    assign coef_we     = accept && (s_data.opcode == ltf_pkg::OP_WR_COEF) &&
                         (s_data.row_select < NUM_ROWS) &&
                         (s_data.column_select < NUM_COORDS);
    assign coef_waddr  = KA_W'({s_data.row_select, s_data.column_select});
    assign coord_we    = accept && (s_data.opcode == ltf_pkg::OP_WR_COORD) &&
                         (s_data.column_select < NUM_COORDS);
    assign coord_waddr = CA_W'(s_data.column_select);
    assign param_we    = accept && (s_data.opcode == ltf_pkg::OP_WR_PARAM) &&
                         (s_data.row_select < NUM_ROWS);
    assign param_waddr = PA_W'(s_data.row_select);

    // memory reads
    assign coord_raddr = CA_W'((state_reg == S_CPHI) ? col_z : col_phi);
    assign coef_raddr  = KA_W'({step_p, step_col});
    assign param_raddr = PA_W'(p_reg);

    // result register handshake
    assign out_free = !out_valid_reg || m_ready;
    assign out_load = (state_reg == S_OCALC) && out_free;
    assign last_p   = (p_reg == ROW_W'(NUM_ROWS - 1));

    // datapath control
    always_comb begin
        ctl.capture    = accept && is_hit;
        ctl.load_dphi  = (state_reg == S_CPHI);
        ctl.load_dz    = (state_reg == S_CZ);
        ctl.coord_zero = (state_reg == S_CZ) ? (col_z >= NUM_COORDS) :
                                               (col_phi >= NUM_COORDS);
        ctl.mac_issue  = (state_reg == S_MAC);
        ctl.mac_z      = step_z;
        ctl.mac_zero   = (step_col >= NUM_COORDS);
        ctl.mac_param  = step_p;
        ctl.acc_clear  = out_load && last_p;
        ctl.sel_param  = p_reg;
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        final_next = final_reg;
        step_next  = step_reg;
        p_next     = p_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && is_hit) begin
                    final_next = s_data.final_hit;
                    p_next     = '0;
                    if (room) begin
                        state_next = S_CPHI;
                    end else begin
                        ovf_next = 1'b1;
                        if (s_data.final_hit) begin
                            state_next = S_ORD;
                        end
                    end
                end
            end
            S_CPHI: begin
                state_next = S_CZ;
            end
            S_CZ: begin
                step_next  = '0;
                state_next = S_MAC;
            end
            S_MAC: begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(2 * NUM_ROWS - 1)) begin
                    step_next  = '0;
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1: begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2: begin
                cnt_next   = cnt_reg + 1'b1;
                state_next = final_reg ? S_ORD : S_IDLE;
            end
            S_ORD: begin
                state_next = S_OCALC;
            end
            S_OCALC: begin
                if (out_free) begin
                    if (last_p) begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end else begin
                        p_next     = p_reg + 1'b1;
                        state_next = S_ORD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register next value
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next                = 1'b1;
            out_data_next.param_number    = p_reg;
            out_data_next.param_value     = fit_value;
            out_data_next.degrees_freedom = ltf_pkg::DOF_W'(cnt_reg);
            out_data_next.too_many_hits   = ovf_reg;
            out_data_next.end_of_run      = last_p;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            final_reg     <= 1'b0;
            step_reg      <= '0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            final_reg     <= final_next;
            step_reg      <= step_next;
            p_reg         <= p_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // sequencer checks
    a_cnt_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_LAYERS))
        else $error("hit counter beyond layer capacity");

    a_mac_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MAC) |-> room)
        else $error("accumulating a hit beyond layer capacity");

    a_track_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && last_p) |=> (cnt_reg == '0) && !ovf_reg && (state_reg == S_IDLE))
        else $error("track state not reset after last result");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({coef_we, coord_we, param_we}))
        else $error("more than one store written by one request");

endmodule

`default_nettype wire

// File: rtl/linearized_track_fit.sv
// linearized_track_fit: top level of the linearized track fit block
// depends on: ltf_pkg, ltf_ram, ltf_mac, ltf_seq
//
//   channel   direction  ports                      payload
//   s_        in         s_valid s_ready s_data     ltf_pkg::ltf_in_t  (hit or load)
//   m_        out        m_valid m_ready m_data     ltf_pkg::ltf_out_t (fitted parameter)
//
// a hit passes cphi, cz, mac, drain1 and drain2, mac feeding the single shared
// multiplier one coefficient per cycle from the coefficient ram; a final hit
// adds ord and ocalc per result for the central parameter ram read. no clearing
// pass after reset: the stores are to be always loaded before use by the user,
// not enforced by the block. a stalled result waits in the output register and
// holds the sequencer; load requests are taken while a last result waits.
`default_nettype none

module linearized_track_fit #(
    parameter int MAX_LAYERS  = ltf_pkg::MAX_LAYERS_DEF,
    parameter int NUM_PARAMS  = ltf_pkg::NUM_PARAMS_DEF,
    parameter int NUM_COORDS  = ltf_pkg::NUM_COORDS_DEF,
    parameter int VALUE_WIDTH = ltf_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire ltf_pkg::ltf_in_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output ltf_pkg::ltf_out_t      m_data
);

    localparam int NUM_ROWS   = ltf_pkg::num_rows(NUM_PARAMS);
    localparam int COEF_DEPTH = NUM_ROWS * ltf_pkg::COL_SPAN;
    localparam int KA_W       = ltf_pkg::addr_bits(COEF_DEPTH);
    localparam int CA_W       = ltf_pkg::addr_bits(NUM_COORDS);
    localparam int PA_W       = ltf_pkg::addr_bits(NUM_ROWS);

    ltf_pkg::ltf_mac_ctl_t          ctl;
    logic [ltf_pkg::FIELD_W-1:0]    fit_value;
    logic                           coef_we;
    logic [KA_W-1:0]                coef_waddr;
    logic [KA_W-1:0]                coef_raddr;
    logic [VALUE_WIDTH-1:0]         coef_rdata;
    logic                           coord_we;
    logic [CA_W-1:0]                coord_waddr;
    logic [CA_W-1:0]                coord_raddr;
    logic [VALUE_WIDTH-1:0]         coord_rdata;
    logic                           param_we;
    logic [PA_W-1:0]                param_waddr;
    logic [PA_W-1:0]                param_raddr;
    logic [VALUE_WIDTH-1:0]         param_rdata;
    logic [VALUE_WIDTH-1:0]         store_wdata;

    // stored values keep the low value bits of the request
    assign store_wdata = s_data.write_value[VALUE_WIDTH-1:0];

    // sequencer and output register
    ltf_seq #(
        .MAX_LAYERS (MAX_LAYERS),
        .NUM_PARAMS (NUM_PARAMS),
        .NUM_COORDS (NUM_COORDS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fit_value   (fit_value),
        .ctl         (ctl),
        .coef_we     (coef_we),
        .coef_waddr  (coef_waddr),
        .coef_raddr  (coef_raddr),
        .coord_we    (coord_we),
        .coord_waddr (coord_waddr),
        .coord_raddr (coord_raddr),
        .param_we    (param_we),
        .param_waddr (param_waddr),
        .param_raddr (param_raddr)
    );

    // coefficient matrix, 16 column slots per row
    ltf_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (COEF_DEPTH)
    ) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (store_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // central stub coordinates
    ltf_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_COORDS)
    ) u_coord_ram (
        .aclk  (aclk),
        .we    (coord_we),
        .waddr (coord_waddr),
        .wdata (store_wdata),
        .raddr (coord_raddr),
        .rdata (coord_rdata)
    );

    // central track parameters
    ltf_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_ROWS)
    ) u_param_ram (
        .aclk  (aclk),
        .we    (param_we),
        .waddr (param_waddr),
        .wdata (store_wdata),
        .raddr (param_raddr),
        .rdata (param_rdata)
    );

    // difference, multiply and accumulate datapath
    ltf_mac #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_PARAMS  (NUM_PARAMS)
    ) u_mac (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .hit_phi     (s_data.hit_phi),
        .hit_z       (s_data.hit_z),
        .coord_rdata (coord_rdata),
        .coef_rdata  (coef_rdata),
        .param_rdata (param_rdata),
        .fit_value   (fit_value)
    );

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for the linearized track fit block
// holds its own fit predictor and checks every fitted parameter in order
// depends on: ltf_pkg, linearized_track_fit
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROWS          = ltf_pkg::NUM_PARAMS_DEF;
    localparam int COORDS        = ltf_pkg::NUM_COORDS_DEF;
    localparam int LAYERS        = ltf_pkg::MAX_LAYERS_DEF;
    localparam int RANDOM_ITEMS  = 270;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;

    localparam logic signed [ltf_pkg::FIELD_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [ltf_pkg::FIELD_W-1:0] VAL_MIN = 32'sh80000000;
    localparam longint LIM32_HI = 64'sd2147483647;
    localparam longint LIM32_LO = -64'sd2147483648;
    localparam longint LIM64_HI = 64'sh7fffffffffffffff;
    localparam longint LIM64_LO = 64'sh8000000000000000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ltf_pkg::ltf_in_t  s_data;
    logic              m_valid;
    logic              m_ready;
    ltf_pkg::ltf_out_t m_data;

    // fit predictor state
    logic signed [ltf_pkg::FIELD_W-1:0] coef_mem   [ROWS][COORDS];
    logic signed [ltf_pkg::FIELD_W-1:0] coord_mem  [COORDS];
    logic signed [ltf_pkg::FIELD_W-1:0] centre_mem [ROWS];
    longint                             acc_sum    [ROWS];
    int unsigned                        hits_taken;
    bit                                 hits_dropped;
    ltf_pkg::ltf_out_t                  fit_results_due [$];

    int failures;
    int stim_count;
    int burst_left;
    bit sender_steady;
    int hold_left;

    linearized_track_fit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // run limit
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic signed [ltf_pkg::FIELD_W-1:0] clamp32(input longint v);
        if (v > LIM32_HI) return VAL_MAX;
        if (v < LIM32_LO) return VAL_MIN;
        return v[31:0];
    endfunction

    function automatic longint add_clamp64(input longint a, input longint b);
        longint s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? LIM64_LO : LIM64_HI;
        return s;
    endfunction

    // update the fit state for one accepted request, queue the parameters it closes
    function automatic void fit_predict(input ltf_pkg::ltf_in_t req);
        longint            dphi;
        longint            dz;
        longint            cf;
        longint            total;
        int unsigned       zc;
        ltf_pkg::ltf_out_t res;
        case (req.opcode)
            ltf_pkg::OP_WR_COEF: begin
                if (req.column_select < COORDS)
                    coef_mem[req.row_select][req.column_select] = req.write_value;
            end
            ltf_pkg::OP_WR_COORD: begin
                if (req.column_select < COORDS) coord_mem[req.column_select] = req.write_value;
            end
            ltf_pkg::OP_WR_PARAM: begin
                centre_mem[req.row_select] = req.write_value;
            end
            default: begin
                if (hits_taken < LAYERS) begin
                    zc   = hits_taken + ltf_pkg::Z_COL_OFFSET;
                    dphi = clamp32(longint'($signed(req.hit_phi))
                                   - longint'(coord_mem[hits_taken]));
                    dz   = clamp32(longint'($signed(req.hit_z)) - longint'(coord_mem[zc]));
                    for (int p = 0; p < ROWS; p++) begin
                        cf = coef_mem[p][hits_taken];
                        acc_sum[p] = add_clamp64(acc_sum[p], cf * dphi);
                        cf = coef_mem[p][zc];
                        acc_sum[p] = add_clamp64(acc_sum[p], cf * dz);
                    end
                    hits_taken++;
                end else begin
                    hits_dropped = 1'b1;
                end
                // closing hit: one parameter per row, then a fresh track
                if (req.final_hit) begin
                    for (int p = 0; p < ROWS; p++) begin
                        total = longint'(centre_mem[p]) + (acc_sum[p] >>> ltf_pkg::FRAC_BITS);
                        res.param_number    = p[ltf_pkg::ROW_W-1:0];
                        res.param_value     = clamp32(total);
                        res.degrees_freedom = hits_taken[ltf_pkg::DOF_W-1:0];
                        res.too_many_hits   = hits_dropped;
                        res.end_of_run      = (p == ROWS - 1);
                        fit_results_due.insert(fit_results_due.size(), res);
                        acc_sum[p] = 0;
                    end
                    hits_taken   = 0;
                    hits_dropped = 1'b0;
                end
            end
        endcase
    endfunction

    // mostly small Q16.16 values, some extremes and some full-range words
    function automatic logic signed [ltf_pkg::FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            4, 5:    return $urandom;
            default: return $urandom_range(0, 32'h80000) - 32'h40000;
        endcase
    endfunction

    function automatic ltf_pkg::ltf_in_t make_load(
        input logic [ltf_pkg::OP_W-1:0]           op,
        input logic [ltf_pkg::ROW_W-1:0]          row,
        input logic [ltf_pkg::COL_W-1:0]          col,
        input logic signed [ltf_pkg::FIELD_W-1:0] value);
        ltf_pkg::ltf_in_t req;
        req.opcode        = op;
        req.row_select    = row;
        req.column_select = col;
        req.write_value   = value;
        req.hit_phi       = $urandom;
        req.hit_z         = $urandom;
        req.final_hit     = 1'($urandom_range(0, 1));
        return req;
    endfunction

    function automatic ltf_pkg::ltf_in_t make_hit(
        input logic signed [ltf_pkg::FIELD_W-1:0] phi,
        input logic signed [ltf_pkg::FIELD_W-1:0] z,
        input logic                               fin);
        ltf_pkg::ltf_in_t req;
        req.opcode        = ltf_pkg::OP_HIT;
        req.row_select    = ltf_pkg::ROW_W'($urandom);
        req.column_select = ltf_pkg::COL_W'($urandom);
        req.write_value   = $urandom;
        req.hit_phi       = phi;
        req.hit_z         = z;
        req.final_hit     = fin;
        return req;
    endfunction

    // offer one request, wait for the handshake, then maybe open a gap
    task automatic send_request(input ltf_pkg::ltf_in_t req);
        int gap;
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        fit_predict(req);
        stim_count++;
        if (!sender_steady) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 25) : $urandom_range(1, 3);
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = $urandom_range(0, 10);
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop offering and wait until every expected parameter has come out, up to the drain limit
    task automatic wait_results_drained();
        int waited;
        if (s_valid) s_valid <= 1'b0;
        waited = 0;
        while (fit_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // every store entry written, so no hit reads an unwritten one
    task automatic load_all_stores();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COORDS; c++)
                send_request(make_load(ltf_pkg::OP_WR_COEF, ltf_pkg::ROW_W'(r),
                                       ltf_pkg::COL_W'(c), pick_value()));
        for (int c = 0; c < COORDS; c++)
            send_request(make_load(ltf_pkg::OP_WR_COORD, 0, ltf_pkg::COL_W'(c),
                                   pick_value()));
        for (int r = 0; r < ROWS; r++)
            send_request(make_load(ltf_pkg::OP_WR_PARAM, ltf_pkg::ROW_W'(r), 0,
                                   pick_value()));
    endtask

    task automatic test_single_hit_track();
        send_request(make_hit(pick_value(), pick_value(), 1'b1));
    endtask

    // seven hits: the last one is beyond capacity and still closes the track
    task automatic test_hit_overflow();
        send_request(make_hit(VAL_MAX, VAL_MIN, 1'b0));
        send_request(make_hit(VAL_MIN, VAL_MAX, 1'b0));
        for (int h = 2; h < 7; h++)
            send_request(make_hit(pick_value(), pick_value(), h == 6));
    endtask

    // accumulator overflow both ways, difference overflow, output clamp
    task automatic test_accumulator_saturation();
        send_request(make_load(ltf_pkg::OP_WR_COEF, 0, 0, VAL_MIN));
        send_request(make_load(ltf_pkg::OP_WR_COEF, 0, 6, VAL_MIN));
        send_request(make_load(ltf_pkg::OP_WR_COEF, 1, 0, VAL_MAX));
        send_request(make_load(ltf_pkg::OP_WR_COEF, 1, 6, VAL_MAX));
        send_request(make_load(ltf_pkg::OP_WR_COEF, 1, 1, VAL_MAX));
        send_request(make_load(ltf_pkg::OP_WR_COEF, 1, 7, VAL_MAX));
        send_request(make_load(ltf_pkg::OP_WR_COORD, 0, 0, '0));
        send_request(make_load(ltf_pkg::OP_WR_COORD, 0, 6, '0));
        send_request(make_load(ltf_pkg::OP_WR_COORD, 0, 1, '0));
        send_request(make_load(ltf_pkg::OP_WR_COORD, 0, 7, '0));
        send_request(make_load(ltf_pkg::OP_WR_COORD, 0, 2, VAL_MAX));
        send_request(make_load(ltf_pkg::OP_WR_COORD, 0, 8, VAL_MIN));
        send_request(make_hit(VAL_MIN, VAL_MIN, 1'b0));
        send_request(make_hit(VAL_MIN, VAL_MIN, 1'b0));
        send_request(make_hit(VAL_MIN, VAL_MAX, 1'b1));
        load_all_stores();
    endtask

    // out-of-range columns dropped, final mark on writes has no effect
    task automatic test_ignored_writes();
        ltf_pkg::ltf_in_t req;
        req = make_load(ltf_pkg::OP_WR_COEF, 2, 12, VAL_MAX);
        req.final_hit = 1'b1;
        send_request(req);
        send_request(make_load(ltf_pkg::OP_WR_COEF, 0, 15, VAL_MIN));
        req = make_load(ltf_pkg::OP_WR_COORD, 3, 13, VAL_MAX);
        req.final_hit = 1'b1;
        send_request(req);
        req = make_load(ltf_pkg::OP_WR_PARAM, 3, 15, pick_value());
        req.final_hit = 1'b1;
        send_request(req);
    endtask

    // long receiver hold while the sender keeps going, then a full pause
    task automatic test_backpressure();
        sender_steady = 1'b1;
        hold_left = HOLD_CYCLES;
        for (int t = 0; t < 4; t++) begin
            send_request(make_hit(pick_value(), pick_value(), 1'b0));
            send_request(make_hit(pick_value(), pick_value(), 1'b1));
        end
        wait_results_drained();
        sender_steady = 1'b0;
    endtask

    task automatic test_random_tracks();
        ltf_pkg::ltf_in_t req;
        int               n_hits;
        stim_count = 0;
        while (stim_count < RANDOM_ITEMS) begin
            sender_steady = ($urandom_range(0, 4) == 0);
            n_hits = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
            for (int h = 0; h < n_hits; h++) begin
                // occasional store update in the middle of a track
                if ($urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       req.opcode = ltf_pkg::OP_WR_COEF;
                        1:       req.opcode = ltf_pkg::OP_WR_COORD;
                        default: req.opcode = ltf_pkg::OP_WR_PARAM;
                    endcase
                    req = make_load(req.opcode,
                                    ltf_pkg::ROW_W'($urandom_range(0, ROWS - 1)),
                                    ltf_pkg::COL_W'(($urandom_range(0, 7) == 0) ?
                                                    $urandom_range(12, 15) :
                                                    $urandom_range(0, 11)),
                                    pick_value());
                    send_request(req);
                end
                send_request(make_hit(pick_value(), pick_value(), h == n_hits - 1));
            end
            // noise: any request with any content
            if ($urandom_range(0, 9) == 0) begin
                req.opcode        = ltf_pkg::OP_W'($urandom);
                req.row_select    = ltf_pkg::ROW_W'($urandom);
                req.column_select = ltf_pkg::COL_W'($urandom);
                req.write_value   = $urandom;
                req.hit_phi       = $urandom;
                req.hit_z         = $urandom;
                req.final_hit     = 1'($urandom);
                send_request(req);
            end
            if ($urandom_range(0, 19) == 0) wait_results_drained();
        end
        sender_steady = 1'b0;
    endtask

    // result side: stalls on a pattern of its own, plus a counted long hold
    initial begin : receiver
        int style;
        int style_left;
        int phase;
        m_ready    = 1'b0;
        style      = 0;
        style_left = 0;
        phase      = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (style_left == 0) begin
                    style      = $urandom_range(0, 2);
                    style_left = $urandom_range(20, 150);
                end
                style_left--;
                phase++;
                case (style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 2) != 0);
                    default: m_ready <= ((phase % 7) < 4);
                endcase
            end
        end
    end

    // compare each accepted result with the oldest expected parameter
    always @(posedge aclk) begin
        ltf_pkg::ltf_out_t due;
        if (aresetn && m_valid && m_ready) begin
            if (fit_results_due.size() == 0) begin
                $error("unexpected result: param %0d value %0d",
                       m_data.param_number, m_data.param_value);
                failures++;
            end else begin
                due = fit_results_due.pop_front();
                if (m_data.param_number !== due.param_number) begin
                    $error("param_number: expected %0d, got %0d",
                           due.param_number, m_data.param_number);
                    failures++;
                end
                if (m_data.param_value !== due.param_value) begin
                    $error("param_value: expected %0d, got %0d",
                           due.param_value, m_data.param_value);
                    failures++;
                end
                if (m_data.degrees_freedom !== due.degrees_freedom) begin
                    $error("degrees_freedom: expected %0d, got %0d",
                           due.degrees_freedom, m_data.degrees_freedom);
                    failures++;
                end
                if (m_data.too_many_hits !== due.too_many_hits) begin
                    $error("too_many_hits: expected %0d, got %0d",
                           due.too_many_hits, m_data.too_many_hits);
                    failures++;
                end
                if (m_data.end_of_run !== due.end_of_run) begin
                    $error("end_of_run: expected %0d, got %0d",
                           due.end_of_run, m_data.end_of_run);
                    failures++;
                end
            end
        end
    end

    // reset, then the test sequence
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        failures      = 0;
        stim_count    = 0;
        burst_left    = 0;
        sender_steady = 1'b0;
        hold_left     = 0;
        hits_taken    = 0;
        hits_dropped  = 1'b0;
        foreach (acc_sum[p]) acc_sum[p] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_all_stores();
        test_single_hit_track();
        test_hit_overflow();
        test_accumulator_saturation();
        test_ignored_writes();
        test_backpressure();
        test_random_tracks();
        wait_results_drained();

        if (fit_results_due.size() != 0) begin
            $error("%0d fitted parameters never arrived", fit_results_due.size());
            failures++;
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
